FILE: src/ubd_pkg.sv
// Shared types, constants and the character map for the URL-safe base64 decoder.
// No dependencies.
package ubd_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned CodeWidth  = 7;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned QueueDepth = 2;

   localparam logic [CodeWidth-1:0] CodeSentinel = 7'd64;
   localparam logic [CodeWidth-1:0] CodeDash     = 7'd62;
   localparam logic [CodeWidth-1:0] CodeUnder    = 7'd63;
   localparam logic [CodeWidth-1:0] CodeLowerOff = 7'd26;
   localparam logic [CodeWidth-1:0] CodeDigitOff = 7'd52;

   typedef logic [CodeWidth-1:0] code_type;
   typedef logic [1:0]           phase_type;

   // Work for the back end: up to three bytes and an optional end marker
   typedef struct packed {
      logic [2:0][ByteWidth-1:0] bytes;
      logic [1:0]                n_bytes;
      logic                      has_end;
      logic                      end_err;
   } job_type;

   function automatic code_type map_char(input logic [CharWidth-1:0] ch);
      code_type res;
      res = CodeSentinel;
      if (ch >= 8'h41 && ch <= 8'h5a) begin
         res = code_type'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7a) begin
         res = code_type'(ch - 8'h61) + CodeLowerOff;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         res = code_type'(ch - 8'h30) + CodeDigitOff;
      end else if (ch == 8'h2d) begin
         res = CodeDash;
      end else if (ch == 8'h5f) begin
         res = CodeUnder;
      end
      return res;
   endfunction

endpackage

FILE: src/ubd_front.sv
// Front end: maps characters, gathers groups of four and builds back-end jobs.
// Depends on ubd_pkg.
module ubd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ubd_pkg::CharWidth-1:0] req_text_char,
   input  logic                          req_is_final,
   output logic                          push_valid,
   input  logic                          push_ready,
   output ubd_pkg::job_type              push_job
);
   import ubd_pkg::*;

   phase_type phase_ff, phase_in;
   logic      stopped_ff, stopped_in;
   code_type  held_ff [3];
   code_type  code;
   code_type  a, b, c, d;
   logic      accept;
   job_type   job;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign code      = map_char(req_text_char);
   assign a         = held_ff[0];
   assign b         = held_ff[1];
   assign c         = held_ff[2];
   assign d         = code;

   always_comb begin
      job           = '0;
      stopped_in    = stopped_ff;
      job.bytes[0]  = {a[5:0], b[5:4]};
      job.bytes[1]  = {b[3:0], c[5:2]};
      job.bytes[2]  = {c[1:0], d[5:0]};
      if (phase_ff == 2'd3 && !stopped_ff) begin
         if (c == CodeSentinel) begin
            job.n_bytes = 2'd1;
            stopped_in  = 1'b1;
         end else if (d == CodeSentinel) begin
            job.n_bytes = 2'd2;
            stopped_in  = 1'b1;
         end else begin
            job.n_bytes = 2'd3;
         end
      end
      phase_in = phase_ff + 2'd1;
      if (req_is_final) begin
         job.has_end = 1'b1;
         job.end_err = (phase_in != 2'd0);
         phase_in    = 2'd0;
         stopped_in  = 1'b0;
      end
   end

   assign push_job   = job;
   assign push_valid = req_valid && (job.n_bytes != 2'd0 || job.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         stopped_ff <= stopped_in;
      end
   end

   // Held codes need no reset: always written before read
   always_ff @(posedge clock) begin
      if (accept && phase_ff != 2'd3) begin
         held_ff[phase_ff] <= code;
      end
   end

endmodule

FILE: src/ubd_queue.sv
// Short job queue between front and back ends.
// Depends on ubd_pkg.
module ubd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ubd_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop,
   output ubd_pkg::job_type pop_job
);
   import ubd_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);
   localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

   job_type               mem [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CntWidth-1:0]   count_ff;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CntWidth'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_job    = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: src/ubd_back.sv
// Back end: walks each job and drives one result per cycle into the output register unless rsp_ready stalls it.
// Depends on ubd_pkg.
module ubd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  ubd_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ubd_pkg::ByteWidth-1:0] rsp_data_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_end_of_string,
   output logic                          rsp_length_error,
   output logic                          rsp_last_of_run
);
   import ubd_pkg::*;

   logic [1:0]           idx_ff;
   logic                 valid_ff;
   logic [ByteWidth-1:0] data_ff, data_in;
   logic                 bvalid_ff, bvalid_in;
   logic                 eos_ff, eos_in;
   logic                 err_ff, err_in;
   logic                 last_ff, last_in;
   logic [2:0]           n_res;
   logic                 load;

   assign load  = job_valid && (!valid_ff || rsp_ready);
   assign n_res = {1'b0, job.n_bytes} + {2'b00, job.has_end};

   always_comb begin
      last_in = ({1'b0, idx_ff} == n_res - 3'd1);
      if (idx_ff < job.n_bytes) begin
         data_in   = job.bytes[idx_ff];
         bvalid_in = 1'b1;
         eos_in    = 1'b0;
         err_in    = 1'b0;
      end else begin
         data_in   = '0;
         bvalid_in = 1'b0;
         eos_in    = 1'b1;
         err_in    = job.end_err;
      end
   end

   assign job_pop = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= last_in ? 2'd0 : idx_ff + 2'd1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff   <= data_in;
         bvalid_ff <= bvalid_in;
         eos_ff    <= eos_in;
         err_ff    <= err_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_valid    = bvalid_ff;
   assign rsp_end_of_string = eos_ff;
   assign rsp_length_error  = err_ff;
   assign rsp_last_of_run   = last_ff;

endmodule

FILE: src/urlsafe_base64_decoder.sv
// URL-safe base64 decoder, one character per transfer, up to four results per character.
// Input: one character a cycle while the job queue has room; results pass the queue entry, then the output register.
// Output: one result a cycle from the output register while rsp_ready takes it; a character causing several results
// holds the back end until all are out, so throughput is set by results per character, not by the front end.
// Reset clears group phase, stop flag, queue pointers and count, result index and output valid; no clearing pass.
// Depends on ubd_pkg, ubd_front, ubd_queue, ubd_back.
module urlsafe_base64_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ubd_pkg::CharWidth-1:0] req_text_char,
   input  logic                          req_is_final,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ubd_pkg::ByteWidth-1:0] rsp_data_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_end_of_string,
   output logic                          rsp_length_error,
   output logic                          rsp_last_of_run
);
   import ubd_pkg::*;

   logic    push_valid, push_ready, pop_valid, pop;
   job_type push_job, pop_job;

   ubd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_char (req_text_char),
      .req_is_final  (req_is_final),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   ubd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   ubd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (pop_valid),
      .job               (pop_job),
      .job_pop           (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_end_of_string (rsp_end_of_string),
      .rsp_length_error  (rsp_length_error),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
